// ===== hdl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// shared types and character codes for the c subset tokeniser
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int LEN_W = 6;

  // lexer modes, held between bytes
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_SLASH = 4'd1,
    M_LINE  = 4'd2,
    M_BLOCK = 4'd3,
    M_BSTAR = 4'd4,
    M_EQ    = 4'd5,
    M_BANG  = 4'd6,
    M_LT    = 4'd7,
    M_GT    = 4'd8,
    M_PLUS  = 4'd9,
    M_NUM   = 4'd10,
    M_ID    = 4'd11,
    M_STR   = 4'd12,
    M_DONE  = 4'd13
  } mode_t;

  typedef enum logic [4:0] {
    T_EOF     = 5'd0,
    T_ID      = 5'd1,
    T_NUM     = 5'd2,
    T_STR     = 5'd3,
    T_SEMI    = 5'd4,
    T_LBRACE  = 5'd5,
    T_RBRACE  = 5'd6,
    T_LPAREN  = 5'd7,
    T_RPAREN  = 5'd8,
    T_ASSIGN  = 5'd9,
    T_PLUS    = 5'd10,
    T_MINUS   = 5'd11,
    T_STAR    = 5'd12,
    T_SLASH   = 5'd13,
    T_PERCENT = 5'd14,
    T_EQEQ    = 5'd15,
    T_NE      = 5'd16,
    T_LT      = 5'd17,
    T_GT      = 5'd18,
    T_LE      = 5'd19,
    T_GE      = 5'd20,
    T_BANG    = 5'd21,
    T_COMMA   = 5'd22
  } tok_t;

  localparam logic REC_CHAR  = 1'b0;
  localparam logic REC_TOKEN = 1'b1;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_EQ      = 8'h3d;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_Z    = 8'h5a;
  localparam logic [7:0] CH_USCORE  = 8'h5f;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_Z    = 8'h7a;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;

  // one result item
  typedef struct packed {
    logic               kind;
    tok_t               ttype;
    logic [31:0]        num;
    logic [7:0]         ch;
    logic [LEN_W-1:0]   len;
    logic               last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= CH_LC_A) && (b <= CH_LC_Z)) || ((b >= CH_UC_A) && (b <= CH_UC_Z)) ||
           (b == CH_USCORE);
  endfunction

  function automatic res_t mk_tok(input tok_t t);
    res_t r;
    r       = '0;
    r.kind  = REC_TOKEN;
    r.ttype = t;
    return r;
  endfunction

endpackage

// ===== hdl/c_subset_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// c_subset_tokenizer_unit
// streaming lexer for a small c subset; while in_stall is low, one source byte per cycle
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | in        | in_valid / in_stall | in_byte
//  out     | out       | out_valid/out_stall | out_rec_kind, out_token_type,
//          |           |                     | out_number_value, out_text_char,
//          |           |                     | out_text_length, out_last_of_run
//
//  a byte is taken per cycle while in_stall is low; its first result reaches
//  the output through the input register, then the two-entry result queue
//  the lexer steps one byte a cycle while the queue can take all its results;
//  a two-result byte waits for the queue to drain through its single output
//  rst_n (synchronous) puts the lexer in idle with zero number and text count
//  in_stall rises only when the queue cannot take all results of the held byte
//
module c_subset_tokenizer_unit #(
  parameter int MAX_TEXT = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_rec_kind,
  output logic [4:0]         out_token_type,
  output logic [31:0]        out_number_value,
  output logic [7:0]         out_text_char,
  output logic [5:0]         out_text_length,
  output logic               out_last_of_run
);
  import cst_pkg::*;

  localparam int CNT_W = $clog2(MAX_TEXT + 1);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // lexer state
  mode_t            mode_r, mode_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // result queue: entry 0 is the head shown on the out port
  res_t       q_r [2];
  res_t       q_nxt [2];
  logic [1:0] q_cnt_r, q_cnt_nxt;

  logic [1:0] res_cnt;
  res_t       res0, res1;
  logic       pop;
  logic [1:0] after_pop;
  logic [2:0] fill;
  logic       step;
  logic       in_take;

  cst_lexer #(
    .MAX_TEXT (MAX_TEXT),
    .CNT_W    (CNT_W)
  ) u_lexer (
    .mode      (mode_r),
    .acc       (acc_r),
    .cnt       (cnt_r),
    .b         (in_byte_r),
    .next_mode (mode_nxt),
    .next_acc  (acc_nxt),
    .next_cnt  (cnt_nxt),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  // head leaves when the sink is not stalling
  assign pop       = (q_cnt_r != 2'd0) && !out_stall;
  assign after_pop = q_cnt_r - {1'b0, pop};
  assign fill      = {1'b0, after_pop} + {1'b0, res_cnt};

  // the held byte is lexed once the queue has room for all of its results
  assign step     = in_vld_r && (fill <= 3'd2);
  assign in_stall = in_vld_r && !step;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) q_nxt[0] = q_r[1];
    if (step) begin
      if (res_cnt != 2'd0) q_nxt[after_pop[0]] = res0;
      // two results only ever land in an empty queue
      if (res_cnt == 2'd2) q_nxt[1] = res1;
    end
    q_cnt_nxt = step ? fill[1:0] : after_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= M_IDLE;
      acc_r    <= '0;
      cnt_r    <= '0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (step) begin
        in_vld_r <= 1'b0;
      end
      if (step) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_byte;
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_valid        = (q_cnt_r != 2'd0);
  assign out_rec_kind     = q_r[0].kind;
  assign out_token_type   = q_r[0].ttype;
  assign out_number_value = q_r[0].num;
  assign out_text_char    = q_r[0].ch;
  assign out_text_length  = q_r[0].len;
  assign out_last_of_run  = q_r[0].last;

endmodule

// ===== hdl/cst_lexer.sv =====
// ----------------------------------------------------------------------------
// cst_lexer
// next-state and result logic for one source byte
// ----------------------------------------------------------------------------
module cst_lexer #(
  parameter int MAX_TEXT = 63,
  parameter int CNT_W    = 6
) (
  input  cst_pkg::mode_t   mode,
  input  logic [31:0]      acc,
  input  logic [CNT_W-1:0] cnt,
  input  logic [7:0]       b,
  output cst_pkg::mode_t   next_mode,
  output logic [31:0]      next_acc,
  output logic [CNT_W-1:0] next_cnt,
  output logic [1:0]       res_cnt,
  output cst_pkg::res_t    res0,
  output cst_pkg::res_t    res1
);
  import cst_pkg::*;

  // what a byte does when no token is pending
  mode_t f_mode;
  logic  f_emit;
  res_t  f_res;
  logic  f_acc_ld;
  logic  f_cnt_set;
  logic  f_cnt_one;

  always_comb begin
    f_mode    = M_IDLE;
    f_emit    = 1'b0;
    f_res     = '0;
    f_acc_ld  = 1'b0;
    f_cnt_set = 1'b0;
    f_cnt_one = 1'b0;
    case (b)
      CH_SPACE, CH_TAB, CH_NL: f_mode = M_IDLE;
      CH_NUL: begin
        f_emit = 1'b1;
        f_res  = mk_tok(T_EOF);
        f_mode = M_DONE;
      end
      CH_SLASH:   f_mode = M_SLASH;
      CH_SEMI:    begin f_emit = 1'b1; f_res = mk_tok(T_SEMI);    end
      CH_LBRACE:  begin f_emit = 1'b1; f_res = mk_tok(T_LBRACE);  end
      CH_RBRACE:  begin f_emit = 1'b1; f_res = mk_tok(T_RBRACE);  end
      CH_LPAREN:  begin f_emit = 1'b1; f_res = mk_tok(T_LPAREN);  end
      CH_RPAREN:  begin f_emit = 1'b1; f_res = mk_tok(T_RPAREN);  end
      CH_COMMA:   begin f_emit = 1'b1; f_res = mk_tok(T_COMMA);   end
      CH_MINUS:   begin f_emit = 1'b1; f_res = mk_tok(T_MINUS);   end
      CH_STAR:    begin f_emit = 1'b1; f_res = mk_tok(T_STAR);    end
      CH_PERCENT: begin f_emit = 1'b1; f_res = mk_tok(T_PERCENT); end
      CH_EQ:      f_mode = M_EQ;
      CH_BANG:    f_mode = M_BANG;
      CH_LT:      f_mode = M_LT;
      CH_GT:      f_mode = M_GT;
      CH_PLUS:    f_mode = M_PLUS;
      CH_DQUOTE: begin
        f_mode    = M_STR;
        f_cnt_set = 1'b1;
      end
      default: begin
        if (is_digit(b)) begin
          f_mode   = M_NUM;
          f_acc_ld = 1'b1;
        end else if (is_alpha(b)) begin
          f_mode     = M_ID;
          f_emit     = 1'b1;
          f_res.kind = REC_CHAR;
          f_res.ttype = T_ID;
          f_res.ch   = b;
          f_cnt_set  = 1'b1;
          f_cnt_one  = 1'b1;
        end else begin
          f_emit = 1'b1;
          f_res  = mk_tok(T_EOF);
          f_mode = M_DONE;
        end
      end
    endcase
  end

  logic        lead_v;
  res_t        lead;
  logic        use_fresh;
  logic [31:0] acc_x10;
  logic        at_cap;

  assign acc_x10 = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
  assign at_cap  = (cnt >= CNT_W'(MAX_TEXT));

  always_comb begin
    next_mode = mode;
    next_acc  = acc;
    next_cnt  = cnt;
    lead_v    = 1'b0;
    lead      = '0;
    use_fresh = 1'b0;
    res0      = '0;
    res1      = '0;
    res_cnt   = 2'd0;

    case (mode)
      M_DONE: next_mode = M_DONE;
      M_SLASH: begin
        if (b == CH_SLASH) begin
          next_mode = M_LINE;
        end else if (b == CH_STAR) begin
          next_mode = M_BLOCK;
        end else begin
          lead_v    = 1'b1;
          lead      = mk_tok(T_SLASH);
          use_fresh = 1'b1;
        end
      end
      M_LINE: begin
        if (b == CH_NL) begin
          next_mode = M_IDLE;
        end else if (b == CH_NUL) begin
          lead_v    = 1'b1;
          lead      = mk_tok(T_EOF);
          next_mode = M_DONE;
        end
      end
      M_BLOCK, M_BSTAR: begin
        if (b == CH_NUL) begin
          lead_v    = 1'b1;
          lead      = mk_tok(T_EOF);
          next_mode = M_DONE;
        end else if (mode == M_BSTAR && b == CH_SLASH) begin
          next_mode = M_IDLE;
        end else if (b == CH_STAR) begin
          next_mode = M_BSTAR;
        end else begin
          next_mode = M_BLOCK;
        end
      end
      M_EQ, M_BANG, M_LT, M_GT: begin
        lead_v = 1'b1;
        if (b == CH_EQ) begin
          next_mode = M_IDLE;
          case (mode)
            M_EQ:    lead = mk_tok(T_EQEQ);
            M_BANG:  lead = mk_tok(T_NE);
            M_LT:    lead = mk_tok(T_LE);
            default: lead = mk_tok(T_GE);
          endcase
        end else begin
          use_fresh = 1'b1;
          case (mode)
            M_EQ:    lead = mk_tok(T_ASSIGN);
            M_BANG:  lead = mk_tok(T_BANG);
            M_LT:    lead = mk_tok(T_LT);
            default: lead = mk_tok(T_GT);
          endcase
        end
      end
      M_PLUS: begin
        lead_v = 1'b1;
        if (b == CH_PLUS) begin
          lead      = mk_tok(T_EOF);
          next_mode = M_DONE;
        end else begin
          lead      = mk_tok(T_PLUS);
          use_fresh = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(b)) begin
          next_acc = acc_x10 + {28'd0, b[3:0]};
        end else begin
          lead_v    = 1'b1;
          lead      = mk_tok(T_NUM);
          lead.num  = acc;
          use_fresh = 1'b1;
        end
      end
      M_ID: begin
        if (is_alpha(b) || is_digit(b)) begin
          if (!at_cap) begin
            lead_v     = 1'b1;
            lead.kind  = REC_CHAR;
            lead.ttype = T_ID;
            lead.ch    = b;
            lead.len   = LEN_W'(cnt);
            next_cnt   = cnt + CNT_W'(1);
          end
        end else begin
          lead_v    = 1'b1;
          lead      = mk_tok(T_ID);
          lead.len  = LEN_W'(cnt);
          use_fresh = 1'b1;
        end
      end
      M_STR: begin
        lead_v = 1'b1;
        if (b == CH_DQUOTE) begin
          lead      = mk_tok(T_STR);
          lead.len  = LEN_W'(cnt);
          next_mode = M_IDLE;
        end else if (b == CH_NUL || at_cap) begin
          lead      = mk_tok(T_STR);
          lead.len  = LEN_W'(cnt);
          use_fresh = 1'b1;
        end else begin
          lead.kind  = REC_CHAR;
          lead.ttype = T_STR;
          lead.ch    = b;
          lead.len   = LEN_W'(cnt);
          next_cnt   = cnt + CNT_W'(1);
        end
      end
      default: use_fresh = 1'b1;
    endcase

    if (use_fresh) begin
      next_mode = f_mode;
      if (f_acc_ld) next_acc = {28'd0, b[3:0]};
      if (f_cnt_set) next_cnt = f_cnt_one ? CNT_W'(1) : '0;
      if (lead_v) begin
        res0    = lead;
        res1    = f_res;
        res_cnt = f_emit ? 2'd2 : 2'd1;
      end else begin
        res0    = f_res;
        res_cnt = f_emit ? 2'd1 : 2'd0;
      end
    end else begin
      res0    = lead;
      res_cnt = lead_v ? 2'd1 : 2'd0;
    end

    // flag the final result of this byte
    if (res_cnt == 2'd2) res1.last = 1'b1;
    else if (res_cnt == 2'd1) res0.last = 1'b1;
  end

endmodule

// ===== dv/tokenizer_check_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tokenizer_check_pkg
// token predictor and result checker for the c subset tokeniser testbench
// ----------------------------------------------------------------------------
package tokenizer_check_pkg;

  import cst_pkg::*;

  class token_scoreboard #(int unsigned CAP = 63);

    mode_t       mode;
    logic [31:0] acc;
    int unsigned text_cnt;
    res_t        tokens_due[$];
    res_t        byte_results[$];
    int unsigned mismatches;

    function new();
      mode       = M_IDLE;
      acc        = '0;
      text_cnt   = 0;
      mismatches = 0;
    endfunction

    function bit digit_ch(logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function bit word_ch(logic [7:0] b);
      return ((b >= CH_LC_A) && (b <= CH_LC_Z)) || ((b >= CH_UC_A) && (b <= CH_UC_Z)) ||
             (b == CH_USCORE);
    endfunction

    function void add(logic kind, tok_t t, logic [31:0] num, logic [7:0] ch,
                      int unsigned len);
      res_t r;
      if (byte_results.size() >= 2) return;
      r.kind  = kind;
      r.ttype = t;
      r.num   = num;
      r.ch    = ch;
      r.len   = len[LEN_W-1:0];
      r.last  = 1'b0;
      byte_results.push_back(r);
    endfunction

    function void add_tok(tok_t t);
      add(REC_TOKEN, t, '0, '0, 0);
    endfunction

    function void stop_text();
      add_tok(T_EOF);
      mode = M_DONE;
    endfunction

    // byte seen with nothing pending
    function void lex_fresh(logic [7:0] b);
      mode = M_IDLE;
      case (b)
        CH_SPACE, CH_TAB, CH_NL: ;
        CH_NUL:     stop_text();
        CH_SLASH:   mode = M_SLASH;
        CH_SEMI:    add_tok(T_SEMI);
        CH_LBRACE:  add_tok(T_LBRACE);
        CH_RBRACE:  add_tok(T_RBRACE);
        CH_LPAREN:  add_tok(T_LPAREN);
        CH_RPAREN:  add_tok(T_RPAREN);
        CH_COMMA:   add_tok(T_COMMA);
        CH_MINUS:   add_tok(T_MINUS);
        CH_STAR:    add_tok(T_STAR);
        CH_PERCENT: add_tok(T_PERCENT);
        CH_EQ:      mode = M_EQ;
        CH_BANG:    mode = M_BANG;
        CH_LT:      mode = M_LT;
        CH_GT:      mode = M_GT;
        CH_PLUS:    mode = M_PLUS;
        CH_DQUOTE: begin
          mode     = M_STR;
          text_cnt = 0;
        end
        default: begin
          if (digit_ch(b)) begin
            mode = M_NUM;
            acc  = 32'(b - CH_ZERO);
          end else if (word_ch(b)) begin
            mode = M_ID;
            add(REC_CHAR, T_ID, '0, b, 0);
            text_cnt = 1;
          end else begin
            stop_text();
          end
        end
      endcase
    endfunction

    // held operator: fold with '=' or emit alone and relex the byte
    function void close_pair(logic [7:0] b, tok_t single, tok_t twin);
      if (b == CH_EQ) begin
        add_tok(twin);
        mode = M_IDLE;
      end else begin
        add_tok(single);
        lex_fresh(b);
      end
    endfunction

    function int unsigned pending_count();
      return tokens_due.size();
    endfunction

    function void note_byte(logic [7:0] b);
      byte_results.delete();
      case (mode)
        M_DONE: ;
        M_SLASH: begin
          if (b == CH_SLASH) mode = M_LINE;
          else if (b == CH_STAR) mode = M_BLOCK;
          else begin
            add_tok(T_SLASH);
            lex_fresh(b);
          end
        end
        M_LINE: begin
          if (b == CH_NL) mode = M_IDLE;
          else if (b == CH_NUL) stop_text();
        end
        M_BLOCK, M_BSTAR: begin
          if (b == CH_NUL) stop_text();
          else if (mode == M_BSTAR && b == CH_SLASH) mode = M_IDLE;
          else if (b == CH_STAR) mode = M_BSTAR;
          else mode = M_BLOCK;
        end
        M_EQ:   close_pair(b, T_ASSIGN, T_EQEQ);
        M_BANG: close_pair(b, T_BANG, T_NE);
        M_LT:   close_pair(b, T_LT, T_LE);
        M_GT:   close_pair(b, T_GT, T_GE);
        M_PLUS: begin
          if (b == CH_PLUS) stop_text();
          else begin
            add_tok(T_PLUS);
            lex_fresh(b);
          end
        end
        M_NUM: begin
          if (digit_ch(b)) acc = acc * 32'd10 + 32'(b - CH_ZERO);
          else begin
            add(REC_TOKEN, T_NUM, acc, '0, 0);
            lex_fresh(b);
          end
        end
        M_ID: begin
          if (word_ch(b) || digit_ch(b)) begin
            if (text_cnt < CAP) begin
              add(REC_CHAR, T_ID, '0, b, text_cnt);
              text_cnt++;
            end
          end else begin
            add(REC_TOKEN, T_ID, '0, '0, text_cnt);
            lex_fresh(b);
          end
        end
        M_STR: begin
          if (b == CH_DQUOTE) begin
            add(REC_TOKEN, T_STR, '0, '0, text_cnt);
            mode = M_IDLE;
          end else if (b == CH_NUL || text_cnt >= CAP) begin
            add(REC_TOKEN, T_STR, '0, '0, text_cnt);
            lex_fresh(b);
          end else begin
            add(REC_CHAR, T_STR, '0, b, text_cnt);
            text_cnt++;
          end
        end
        default: lex_fresh(b);
      endcase
      if (byte_results.size() != 0) byte_results[byte_results.size() - 1].last = 1'b1;
      foreach (byte_results[i]) tokens_due.push_back(byte_results[i]);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d type %0d num %0d char %0d len %0d last %0d",
                   $time, got.kind, got.ttype, got.num, got.ch, got.len, got.last);
        return;
      end
      want = tokens_due.pop_front();
      if (got.kind !== want.kind || got.ttype !== want.ttype || got.num !== want.num ||
          got.ch !== want.ch || got.len !== want.len || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: token mismatch", $time);
          $display("  want kind %0d type %0d num %0d char %0d len %0d last %0d",
                   want.kind, want.ttype, want.num, want.ch, want.len, want.last);
          $display("  got  kind %0d type %0d num %0d char %0d len %0d last %0d",
                   got.kind, got.ttype, got.num, got.ch, got.len, got.last);
        end
      end
    endfunction

  endclass

endpackage

// ===== dv/c_subset_tokenizer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_subset_tokenizer_unit_tb
// feeds source text to the tokeniser byte by byte and checks every result
// against an independent token predictor, with random gaps and stalls on
// both channels; the text ends once, in one of the ways that raise eof
// ----------------------------------------------------------------------------
module c_subset_tokenizer_unit_tb;

  import cst_pkg::*;
  import tokenizer_check_pkg::*;

  localparam int unsigned TEXT_CAP = 63;

  // ways of ending the text, one per run
  typedef enum int unsigned {
    END_NUL,
    END_UNKNOWN,
    END_PLUS_PLUS,
    END_OPEN_LINE,
    END_OPEN_BLOCK,
    END_OPEN_STRING
  } text_end_e;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_rec_kind;
  logic [4:0]  out_token_type;
  logic [31:0] out_number_value;
  logic [7:0]  out_text_char;
  logic [5:0]  out_text_length;
  logic        out_last_of_run;

  tokenizer_check_pkg::token_scoreboard #(TEXT_CAP) sb = new();

  // sender bookkeeping
  int unsigned burst_left  = 0;   // items still to go without any gap
  int unsigned bytes_sent  = 0;
  int unsigned stall_phase = 0;
  logic [7:0]  last_src    = 8'h00;

  // character sets for the generator
  string word_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string digit_set = "0123456789";
  string noise_set = " \t\n;{}()=!<>-*%,09azZ_";
  string str_stops = "\"; k";
  string op_text [19] = '{"=", "==", "!", "!=", "<", "<=", ">", ">=", "+", "-", "*",
                          "/", "%", ";", "{", "}", "(", ")", ","};
  string big_nums [4] = '{"0", "4294967295", "4294967296", "18446744073709551617"};
  string pend_text [5] = '{"", "tail", "42", "<", "/"};

  c_subset_tokenizer_unit #(
    .MAX_TEXT (TEXT_CAP)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rec_kind     (out_rec_kind),
    .out_token_type   (out_token_type),
    .out_number_value (out_number_value),
    .out_text_char    (out_text_char),
    .out_text_length  (out_text_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle length: mostly none, otherwise short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // true for any byte the lexer can start a token or a skip with
  function automatic bit starts_token(logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_NL, CH_SLASH, CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN,
      CH_RPAREN, CH_COMMA, CH_MINUS, CH_STAR, CH_PERCENT, CH_EQ, CH_BANG, CH_LT,
      CH_GT, CH_PLUS, CH_DQUOTE: return 1'b1;
      default: return ((b >= CH_ZERO) && (b <= CH_NINE)) ||
                      ((b >= CH_LC_A) && (b <= CH_LC_Z)) ||
                      ((b >= CH_UC_A) && (b <= CH_UC_Z)) || (b == CH_USCORE);
    endcase
  endfunction

  // one item on the input channel; valid stays high if the next item follows
  // straight on, so it is only ever lowered by a gap or by the caller
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (burst_left != 0) ? 0 : pick_gap();
    if (burst_left != 0) burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    last_src = b;
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // stop fragments from fusing into '++' or into an unplanned comment opener
  task automatic keep_apart(input logic [7:0] first);
    if ((last_src == CH_PLUS && first == CH_PLUS) ||
        (last_src == CH_SLASH && (first == CH_SLASH || first == CH_STAR)))
      push_byte(CH_SPACE);
  endtask

  // one well-formed piece of source, or a little harmless noise, then maybe
  // some white space; nothing here can raise eof
  task automatic gen_fragment();
    int unsigned r;
    int unsigned n;
    logic [7:0]  b;
    logic [7:0]  prev;
    string       s;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      // identifier, now and then past the text cap
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 8);
      push_byte(pick_from(word_set));
      repeat (n - 1)
        push_byte(($urandom_range(0, 3) == 0) ? pick_from(digit_set) : pick_from(word_set));
    end else if (r < 40) begin
      // number, sometimes one that wraps
      if ($urandom_range(0, 9) == 0) begin
        push_text(big_nums[$urandom_range(0, 3)]);
      end else begin
        repeat ($urandom_range(1, 10)) push_byte(pick_from(digit_set));
      end
    end else if (r < 70) begin
      s = op_text[$urandom_range(0, 18)];
      keep_apart(s[0]);
      push_text(s);
    end else if (r < 80) begin
      // string with any content but the quote and nul; at the cap it may end abruptly
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, TEXT_CAP) : $urandom_range(0, 10);
      push_byte(CH_DQUOTE);
      repeat (n) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_DQUOTE);
        push_byte(b);
      end
      push_byte((n == TEXT_CAP) ? pick_from(str_stops) : CH_DQUOTE);
    end else if (r < 88) begin
      keep_apart(CH_SLASH);
      push_text("//");
      repeat ($urandom_range(0, 12)) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
        push_byte(b);
      end
      push_byte(CH_NL);
    end else if (r < 95) begin
      // block comment, star heavy, never closed early
      keep_apart(CH_SLASH);
      push_text("/*");
      prev = CH_NUL;
      repeat ($urandom_range(0, 12)) begin
        b = ($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(1, 255));
        if (prev == CH_STAR && b == CH_SLASH) b = CH_STAR;
        push_byte(b);
        prev = b;
      end
      push_text("*/");
    end else begin
      b = pick_from(noise_set);
      keep_apart(b);
      push_byte(b);
      repeat ($urandom_range(0, 5)) push_byte(pick_from(noise_set));
    end
    r = $urandom_range(0, 99);
    if (r >= 40) begin
      n = (r < 85) ? 1 : $urandom_range(2, 4);
      repeat (n) push_byte(pick_from(" \t\n"));
    end
  endtask

  // capture of accepted source bytes into the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_byte);
  end

  // check of every accepted result item
  always @(posedge clk) begin : result_mon
    res_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.kind  = out_rec_kind;
      seen.ttype = tok_t'(out_token_type);
      seen.num   = out_number_value;
      seen.ch    = out_text_char;
      seen.len   = out_text_length;
      seen.last  = out_last_of_run;
      sb.check_result(seen);
    end
  end

  // receiver back-pressure: stall bursts between flowing stretches, some of
  // which are long enough to run with no stall at all
  always @(posedge clk) begin
    if (stall_phase != 0) begin
      stall_phase--;
    end else if (out_stall) begin
      out_stall   <= 1'b0;
      stall_phase = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(0, 8);
    end else begin
      stall_phase = pick_gap();
      if (stall_phase != 0) begin
        out_stall <= 1'b1;
        stall_phase--;
      end
    end
  end

  // hard stop, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    string      opener;
    logic [7:0] b;
    bit         drained;
    text_end_e  how;
    drained = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: operators alone and paired, the split of a held
    // operator, a double result on one byte, a short string
    push_text("_zZ0=9!=<=>==+-*/%,!x<\"a\"");

    // random text, with one full drain of the results half way
    while (bytes_sent < 830) begin
      if (burst_left == 0 && $urandom_range(0, 39) == 0) burst_left = $urandom_range(40, 120);
      gen_fragment();
      if (!drained && bytes_sent >= 450) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_count() != 0);
        drained = 1'b1;
      end
    end

    // end the text in one of the ways that raise eof
    how = text_end_e'($urandom_range(0, 5));
    case (how)
      END_NUL: begin
        // any pending token goes out ahead of eof
        opener = pend_text[$urandom_range(0, 4)];
        if (opener.len() != 0) keep_apart(opener[0]);
        push_text(opener);
        push_byte(CH_NUL);
      end
      END_UNKNOWN: begin
        do b = 8'($urandom_range(1, 255)); while (starts_token(b));
        push_byte(b);
      end
      END_PLUS_PLUS: begin
        keep_apart(CH_PLUS);
        push_text("++");
      end
      END_OPEN_LINE: begin
        keep_apart(CH_SLASH);
        push_text("//open");
        push_byte(CH_NUL);
      end
      END_OPEN_BLOCK: begin
        keep_apart(CH_SLASH);
        push_text("/*open*");
        push_byte(CH_NUL);
      end
      default: begin
        push_text("\"open");
        push_byte(CH_NUL);
      end
    endcase

    // after eof every byte must be swallowed, high bit set or not
    push_byte(8'hff);
    push_byte(8'h80);
    repeat (10) push_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    do @(posedge clk); while (sb.pending_count() != 0);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cst_pkg.sv
hdl/cst_lexer.sv
hdl/c_subset_tokenizer_unit.sv
dv/tokenizer_check_pkg.sv
dv/c_subset_tokenizer_unit_tb.sv
